// ===== hw/rtl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants for the percent-decode stream
// Holds the transfer payload types, the command passed from the front end to
// the back end, the held-escape state encoding and the hex digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  // Escape introducer character.
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Depth of the command queue between front end and back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Most bytes one input transfer can produce.
  localparam int MAX_BYTES = 3;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Output transfer payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One classified input: up to three bytes to emit, in order from index 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                count;
    logic                      last;
  } cmd_t;

  // What the front end is holding between transfers.
  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  // True when the byte is a hex digit of either case.
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // Nibble value of a hex digit; the result is meaningless for other bytes.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pds_front.sv =====
// ----------------------------------------------------------------------------
// pds_front: input classifier
// Accepts one raw byte per transfer, tracks a pending escape and turns every
// input into a command of zero to three bytes for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_front
  import pds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  held_t      state;
  held_t      state_next;
  logic [7:0] held_digit;
  logic       accept;
  logic       b_hex;
  logic       b_pct;
  logic       b_last;
  logic [7:0] b;

  assign b      = in_data.in_byte;
  assign b_last = in_data.in_last;
  assign b_hex  = is_hex(b);
  assign b_pct  = (b == PCT_CHAR);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next held state.
  always_comb begin
    state_next = HELD_NONE;
    unique case (state)
      HELD_PCT: begin
        if (b_hex && !b_last) begin
          state_next = HELD_DIGIT;
        end else if (b_pct && !b_last) begin
          state_next = HELD_PCT;
        end
      end
      HELD_DIGIT: begin
        if (!b_hex && b_pct && !b_last) begin
          state_next = HELD_PCT;
        end
      end
      default: begin
        if (b_pct && !b_last) begin
          state_next = HELD_PCT;
        end
      end
    endcase
  end

  // Bytes released by this input.
  always_comb begin
    q_cmd       = '0;
    q_cmd.last  = b_last;
    unique case (state)
      HELD_PCT: begin
        if (!(b_hex && !b_last)) begin
          q_cmd.bytes[0] = PCT_CHAR;
          if (b_pct && !b_last) begin
            q_cmd.count = 2'd1;
          end else begin
            q_cmd.bytes[1] = b;
            q_cmd.count    = 2'd2;
          end
        end
      end
      HELD_DIGIT: begin
        if (b_hex) begin
          q_cmd.bytes[0] = {hex_nibble(held_digit), hex_nibble(b)};
          q_cmd.count    = 2'd1;
        end else begin
          q_cmd.bytes[0] = PCT_CHAR;
          q_cmd.bytes[1] = held_digit;
          if (b_pct && !b_last) begin
            q_cmd.count = 2'd2;
          end else begin
            q_cmd.bytes[2] = b;
            q_cmd.count    = 2'd3;
          end
        end
      end
      default: begin
        if (!(b_pct && !b_last)) begin
          q_cmd.bytes[0] = b;
          q_cmd.count    = 2'd1;
        end
      end
    endcase
  end

  // Only commands that carry bytes enter the queue.
  assign q_push = accept && (q_cmd.count != 2'd0);

  // Held state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HELD_NONE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // The first hex digit of an escape is kept until its partner arrives.
  always_ff @(posedge clk) begin
    if (accept && (state_next == HELD_DIGIT)) begin
      held_digit <= b;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pds_queue.sv =====
// ----------------------------------------------------------------------------
// pds_queue: command queue
// A short first-in first-out buffer that lets the front end keep accepting
// while the back end is still serializing earlier commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_queue
  import pds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Write side storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pds_back.sv =====
// ----------------------------------------------------------------------------
// pds_back: output serializer
// Walks the head command's bytes one per cycle, unless the output stalls, into
// a registered output stage and retires the command with its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_back
  import pds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire cmd_t head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  // The output register takes a byte when it is empty or being drained.
  assign load   = head_valid && (!out_valid || out_ready);
  assign at_end = (idx == (head_cmd.count - 2'd1));
  assign pop    = load && at_end;

  // Byte index within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; the string end flag rides only on the last byte.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte <= head_cmd.bytes[idx];
      out_data.out_last <= head_cmd.last && at_end;
    end
  end

`ifndef SYNTHESIS
  // The queue never holds a command without bytes.
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head_cmd.count != 2'd0))
    else $error("pds_back: empty command at queue head");

  // The index stays inside the head command.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < head_cmd.count))
    else $error("pds_back: byte index past end of command");

  // A stalled output register is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("pds_back: output overwritten while stalled");

  // With nothing queued the index rests at the start of a command.
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (idx == 2'd0))
    else $error("pds_back: index not at zero while queue is empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/percent_decode_stream.sv =====
// ----------------------------------------------------------------------------
// percent_decode_stream: streaming URL percent decoder
// Decodes %XX escapes one raw byte per transfer; malformed or truncated
// escapes pass through literally and the string end flag follows the data.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                          Payload
//   in        in_valid / in_ready / in_data    in_item_t  (in_byte, in_last)
//   out       out_valid / out_ready / out_data out_item_t (out_byte, out_last)
//
// One input transfer is accepted per cycle while the four-entry command queue
// has room. The serializer emits one output byte per cycle unless the output
// stalls; an input releasing three bytes holds the back end while the queue
// absorbs inputs. Bytes pass the queue and then the output register.
// Reset is synchronous; it clears the held escape, the queue and the output.
// Either side may stall at any time without loss of data.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_decode_stream
  import pds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  // Classifier front end.
  pds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Command queue.
  pds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // Serializer back end.
  pds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
